// ----- rtl/tmsa_pkg.sv -----
// shared types and constants for the temporary mapping slot allocator
package tmsa_pkg;

    localparam int SLOTS_DEFAULT          = 64;
    localparam int PHYS_ADDR_BITS_DEFAULT = 36;

    localparam int PAGE_SHIFT   = 12;
    localparam int ADDR_W       = 36;
    localparam int SLOT_FIELD_W = 6;

    // present and writable flags of a page-table entry
    localparam logic [PAGE_SHIFT-1:0] ENTRY_FLAGS = 12'h003;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [ADDR_W-1:0]       phys_addr;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    full_error;
        logic [ADDR_W-1:0]       entry_word;
    } out_item_t;

endpackage

// ----- rtl/temp_mapping_slot_allocator_core.sv -----
// next-fit allocator over a window of temporary page-table slots
//
// usage:
//   s_valid/s_ready/s_item take one request per beat: op map hands in a
//   physical address, op unmap names a slot to release.
//   m_valid/m_ready/m_item give exactly one result beat per request: the
//   chosen (or echoed) slot, full_error, and the entry word written.
// timing:
//   a map scans the present marks one slot per cycle from the search hint,
//   then registers its result; the scan examines 1 up to SLOTS slots
//   (SLOTS when the window is full).
//   an unmap skips the scan. one request is in work at a time; the single
//   scan step (one present-mark read and compare per cycle) sets the rate.
// reset:
//   aresetn low clears every present mark, sets the hint to slot 0 and
//   drops any pending result. stored frames are left as they are.
// stalls:
//   a finished result sits in the output register until m_ready; the next
//   request is accepted meanwhile and completes once that register frees.
module temp_mapping_slot_allocator_core #(
    parameter int SLOTS          = tmsa_pkg::SLOTS_DEFAULT,
    parameter int PHYS_ADDR_BITS = tmsa_pkg::PHYS_ADDR_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tmsa_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tmsa_pkg::out_item_t m_item
);
    import tmsa_pkg::*;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXT_W   = SLOT_W + SLOT_FIELD_W;
    localparam int FRAME_W = PHYS_ADDR_BITS - PAGE_SHIFT;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          req_reg, req_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] hint_reg, hint_next;
    logic [SLOTS-1:0]  present_reg;
    out_item_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic [FRAME_W-1:0] frame_mem [SLOTS];

    logic                      out_free;
    logic                      commit;
    logic                      map_commit;
    logic                      unmap_commit;
    logic [EXT_W-1:0]          idx_ext;
    logic                      idx_in_range;
    logic [SLOT_W-1:0]         idx_slot;
    logic [SLOT_W-1:0]         pos_inc;
    logic [EXT_W-1:0]          pos_ext;
    logic [PHYS_ADDR_BITS-1:0] addr_wide;
    logic [FRAME_W-1:0]        frame;
    logic [ADDR_W-1:0]         entry;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_FINISH) && out_free;

    assign idx_ext      = {{SLOT_W{1'b0}}, req_reg.slot_index};
    assign idx_in_range = idx_ext < EXT_W'(SLOTS);
    assign idx_slot     = idx_ext[SLOT_W-1:0];

    assign map_commit   = commit && (req_reg.op == OP_MAP) && found_reg;
    assign unmap_commit = commit && (req_reg.op == OP_UNMAP) && idx_in_range;

    assign pos_inc = (pos_reg == SLOT_W'(SLOTS - 1)) ? '0 : pos_reg + 1'b1;
    assign pos_ext = {{SLOT_FIELD_W{1'b0}}, pos_reg};

    // bits above the physical address width drop out here
    assign addr_wide = PHYS_ADDR_BITS'(req_reg.phys_addr);
    assign frame     = addr_wide[PHYS_ADDR_BITS-1:PAGE_SHIFT];
    assign entry     = ADDR_W'({frame, ENTRY_FLAGS});

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        pos_next     = pos_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        hint_next    = hint_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_item;
                    pos_next   = hint_reg;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = (s_item.op == OP_MAP) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                // one present mark examined per cycle
                if (!present_reg[pos_reg]) begin
                    found_next = 1'b1;
                    state_next = ST_FINISH;
                end else if (cnt_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (req_reg.op == OP_MAP) begin
                        out_next.full_error = !found_reg;
                        out_next.slot       = found_reg ? pos_ext[SLOT_FIELD_W-1:0] : '0;
                        out_next.entry_word = found_reg ? entry : '0;
                        if (found_reg) begin
                            hint_next = pos_inc;
                        end
                    end else begin
                        out_next.full_error = 1'b0;
                        out_next.slot       = req_reg.slot_index;
                        out_next.entry_word = '0;
                        if (idx_in_range) begin
                            hint_next = idx_slot;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hint_reg    <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            cnt_reg     <= '0;
            pos_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            hint_reg    <= hint_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= '0;
        end else if (map_commit) begin
            present_reg[pos_reg] <= 1'b1;
        end else if (unmap_commit) begin
            present_reg[idx_slot] <= 1'b0;
        end
    end

    // frame store, written on map
    always_ff @(posedge aclk) begin
        if (map_commit) begin
            frame_mem[pos_reg] <= frame;
        end
    end

    a_map_marks_present: assert property (@(posedge aclk) disable iff (!aresetn)
        map_commit |=> present_reg[$past(pos_reg)])
        else $error("mapped slot not marked present");

    a_full_result_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.full_error) |-> (out_reg.slot == '0 && out_reg.entry_word == '0))
        else $error("full result carries slot or entry");

    a_hint_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        EXT_W'(hint_reg) < EXT_W'(SLOTS))
        else $error("search hint outside window");

    a_scan_found_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && found_reg) |-> !present_reg[pos_reg])
        else $error("chosen slot already present");

    a_map_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.op == OP_MAP) |=> state_reg == ST_SCAN)
        else $error("map request did not start a scan");

endmodule
